[hw/rtl/lcs_pkg.sv]
// Shared constants, types and a helper function of the line centroid steering block.
package lcs_pkg;

  // Longest row that is counted; later columns are ignored.
  localparam int MAX_WIDTH = 1024;

  // Column counter, pixel count and running column sum widths.
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = $clog2(MAX_WIDTH * (MAX_WIDTH - 1) / 2 + 1);
  localparam int REM_W  = COL_W + 1;
  localparam int ITER_W = $clog2(SUM_W + 1);

  // Register field widths.
  localparam int THR_W  = 8;
  localparam int RW_W   = 11;
  localparam int BASE_W = 8;
  localparam int CTR_W  = RW_W - 1;

  // Offset and speed arithmetic widths.
  localparam int D_W     = ((COL_W > CTR_W) ? COL_W : CTR_W) + 1;
  localparam int SPDS_W  = D_W + 1;
  localparam int SPEED_W = 11;
  localparam logic [SPEED_W-1:0] SPEED_CAP = 11'd1279;

  // Reset values of the registers and held speeds.
  localparam logic [THR_W-1:0]   THR_RST   = 8'd250;
  localparam logic [RW_W-1:0]    RW_RST    = 11'd150;
  localparam logic [BASE_W-1:0]  BASE_RST  = 8'd20;
  localparam logic [SPEED_W-1:0] SPEED_RST = 11'd20;

  // Configuration register map (word index on the address bus).
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // Steering codes.
  localparam logic [1:0] STEER_FWD   = 2'd0;
  localparam logic [1:0] STEER_LEFT  = 2'd1;
  localparam logic [1:0] STEER_RIGHT = 2'd2;

  // Control from the sequencer to the pixel accumulator.
  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctl_t;

  // Limit a speed sum to the largest speed that can be issued.
  function automatic logic [SPEED_W-1:0] cap_speed(input logic [SPDS_W-1:0] v);
    if (v > SPDS_W'(SPEED_CAP)) begin
      return SPEED_CAP;
    end
    return v[SPEED_W-1:0];
  endfunction

endpackage

[hw/rtl/lcs_accum.sv]
// Pixel accumulator: white test, column counter, white column sum and count.
module lcs_accum
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  acc_ctl_t         ctl,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic [THR_W-1:0] threshold,
  output logic [SUM_W-1:0] col_sum,
  output logic [COL_W-1:0] white_cnt
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [COL_W-1:0] cnt_r, cnt_nxt;
  logic             white;

  assign white = (red > threshold) && (green > threshold) && (blue > threshold);

  // Count a pixel while the row is still inside the counted width.
  always_comb begin
    col_nxt = col_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      col_nxt = '0;
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (ctl.take && (col_r < COL_W'(MAX_WIDTH))) begin
      col_nxt = col_r + 1'b1;
      if (white) begin
        sum_nxt = sum_r + SUM_W'(col_r);
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign col_sum   = sum_r;
  assign white_cnt = cnt_r;

endmodule

[hw/rtl/lcs_div.sv]
// Restoring divider that retires one quotient bit per cycle.
module lcs_div
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [COL_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [COL_W-1:0]  dvs_r, dvs_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // One shift, compare and subtract step.
  assign trial = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign fits  = trial >= REM_W'(dvs_r);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      iter_nxt = ITER_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? (trial - REM_W'(dvs_r)) : trial;
      iter_nxt = iter_r - 1'b1;
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      iter_r <= iter_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/lcs_steer.sv]
// Offset to wheel speed mapping, held speeds and the result word register.
module lcs_steer
  import lcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              lost,
  input  logic [SUM_W-1:0]  quotient,
  input  logic [RW_W-1:0]   row_width,
  input  logic [BASE_W-1:0] base_speed,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SPEED_W-1:0] left_speed,
  output logic [SPEED_W-1:0] right_speed,
  output logic [1:0]        steer,
  output logic              line_lost
);

  logic [SPEED_W-1:0] held_l_r, held_l_nxt;
  logic [SPEED_W-1:0] held_r_r, held_r_nxt;
  logic               vld_r, vld_nxt;
  logic [SPEED_W-1:0] left_r, right_r;
  logic [1:0]         steer_r, steer_nxt;
  logic               lost_r;
  logic [D_W-1:0]     d;
  logic [D_W-1:0]     d_abs;
  logic [SPEED_W-1:0] spd_base, spd_turn;

  // Offset of the white centroid from the centre column.
  assign d        = D_W'(row_width[RW_W-1:1]) - D_W'(quotient[COL_W-1:0]);
  assign d_abs    = d[D_W-1] ? (~d + 1'b1) : d;
  assign spd_base = cap_speed(SPDS_W'(base_speed));
  assign spd_turn = cap_speed(SPDS_W'(base_speed) + SPDS_W'(d_abs[D_W-2:0]));

  // New held speeds on a row with a line; otherwise keep the old ones.
  always_comb begin
    held_l_nxt = held_l_r;
    held_r_nxt = held_r_r;
    steer_nxt  = STEER_FWD;
    if (load && !lost) begin
      if (d[D_W-1]) begin
        held_l_nxt = spd_turn;
        held_r_nxt = spd_base;
        steer_nxt  = STEER_RIGHT;
      end else if (d != '0) begin
        held_l_nxt = spd_base;
        held_r_nxt = spd_turn;
        steer_nxt  = STEER_LEFT;
      end else begin
        held_l_nxt = spd_base;
        held_r_nxt = spd_base;
      end
    end
  end

  // Result word stays until the sink takes it.
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r <= SPEED_RST;
      held_r_r <= SPEED_RST;
      vld_r    <= 1'b0;
    end else begin
      held_l_r <= held_l_nxt;
      held_r_r <= held_r_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= held_l_nxt;
      right_r <= held_r_nxt;
      steer_r <= steer_nxt;
      lost_r  <= lost;
    end
  end

  assign out_valid   = vld_r;
  assign left_speed  = left_r;
  assign right_speed = right_r;
  assign steer       = steer_r;
  assign line_lost   = lost_r;

endmodule

[hw/rtl/line_centroid_steering.sv]
// Top level of the line centroid steering block: sequencer and configuration port.
//
// Pixels of a camera row arrive one word per cycle on the in_ stream and are
// taken back to back while the row lasts; each white pixel (all channels above
// white_threshold) adds its column to a running sum. The pixel marked by
// in_tlast ends the row: the block then drops in_tready, divides the column
// sum by the white count in one restoring divider that retires one quotient
// bit per cycle, and maps the centroid offset to wheel speeds. When the row
// held no white pixel the divider is skipped. The row end also waits while
// the previous result word still waits on the out_ stream. The result word
// sits in an output register, so the next row's pixels are accepted while it
// waits to be taken.
module line_centroid_steering
  import lcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: red [7:0], green [15:8], blue [23:16]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              in_tlast,
  // out_tdata: left_speed_half [10:0], right_speed_half [21:11], steer [23:22]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  // out_tuser: line_lost [0]
  output logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              lost_r, lost_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [RW_W-1:0]   rw_r, rw_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic              cfg_wr;
  logic              in_take;
  acc_ctl_t          acc_ctl;
  logic [SUM_W-1:0]  col_sum;
  logic [COL_W-1:0]  white_cnt;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic              load;
  logic [SPEED_W-1:0] left_speed, right_speed;
  logic [1:0]        steer;
  logic              line_lost;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    thr_nxt  = thr_r;
    rw_nxt   = rw_r;
    base_nxt = base_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_THRESH: thr_nxt  = cfg_pwdata[THR_W-1:0];
        REG_WIDTH:  rw_nxt   = cfg_pwdata[RW_W-1:0];
        REG_BASE:   base_nxt = cfg_pwdata[BASE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_THRESH: cfg_prdata = 32'(thr_r);
      REG_WIDTH:  cfg_prdata = 32'(rw_r);
      REG_BASE:   cfg_prdata = 32'(base_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Row sequencer.
  assign in_tready = (state_r == ST_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign load      = (state_r == ST_DONE) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt     = state_r;
    lost_nxt      = lost_r;
    div_start     = 1'b0;
    acc_ctl.take  = in_take;
    acc_ctl.clear = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take && in_tlast) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        acc_ctl.clear = 1'b1;
        lost_nxt      = (white_cnt == '0);
        if (white_cnt == '0) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lost_r  <= 1'b0;
      thr_r   <= THR_RST;
      rw_r    <= RW_RST;
      base_r  <= BASE_RST;
    end else begin
      state_r <= state_nxt;
      lost_r  <= lost_nxt;
      thr_r   <= thr_nxt;
      rw_r    <= rw_nxt;
      base_r  <= base_nxt;
    end
  end

  lcs_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .threshold (thr_r),
    .col_sum   (col_sum),
    .white_cnt (white_cnt)
  );

  lcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (col_sum),
    .divisor  (white_cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  lcs_steer u_steer (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .lost        (lost_r),
    .quotient    (quotient),
    .row_width   (rw_r),
    .base_speed  (base_r),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .steer       (steer),
    .line_lost   (line_lost)
  );

  assign out_tdata = {steer, right_speed, left_speed};
  assign out_tuser = line_lost;

endmodule

[hw/rtl/lcs_checker.sv]
// Port-level checks of the line centroid steering block, bound to the top level.
module lcs_checker
  import lcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Inside a row the block stays ready for the next pixel after each one it takes.
  a_row_streams: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input stalled inside a row");

  // The row end starts the centroid computation, which blocks input.
  a_row_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after a row end");

  // A lost line never reports a turn.
  a_lost_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:22] == STEER_FWD)
    else $error("turn reported with line lost");

endmodule

bind line_centroid_steering lcs_checker u_lcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/tb_line_centroid_steering.sv]
// Self-checking testbench for the line centroid steering block.
`timescale 1ns / 100ps

module tb_line_centroid_steering;
  import lcs_pkg::*;

  // One camera pixel waiting to be driven, with the idle cycles placed before it.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    int         gap;
  } pixel_t;

  // One wheel command word as the block should issue it.
  typedef struct packed {
    logic [SPEED_W-1:0] left;
    logic [SPEED_W-1:0] right;
    logic [1:0]         steer;
    logic               lost;
  } wheel_cmd_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // in_tdata: red [7:0], green [15:8], blue [23:16]
  logic [23:0]       in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // out_tdata: left_speed_half [10:0], right_speed_half [21:11], steer [23:22]
  logic [23:0]       out_tdata;
  // out_tuser: line_lost [0]
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  line_centroid_steering u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  pixel_t     pixel_q[$];
  wheel_cmd_t cmd_q[$];
  int         mismatch_count = 0;
  bit         burst_row = 1'b0;

  // Shadow of the configuration registers.
  logic [THR_W-1:0]  thr_cfg = THR_RST;
  logic [RW_W-1:0]   width_cfg = RW_RST;
  logic [BASE_W-1:0] base_cfg = BASE_RST;

  // Shadow of the row accumulator and the held speeds.
  logic [COL_W-1:0]   col_idx = '0;
  logic [SUM_W-1:0]   col_sum = '0;
  logic [COL_W-1:0]   white_cnt = '0;
  logic [SPEED_W-1:0] held_left = SPEED_RST;
  logic [SPEED_W-1:0] held_right = SPEED_RST;

  initial begin
    forever #10 clk = ~clk;
  end

  // Clamp a signed speed sum into the range of the speed outputs.
  function automatic logic [SPEED_W-1:0] clamp_speed(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(SPEED_CAP)) begin
      return SPEED_CAP;
    end
    return v[SPEED_W-1:0];
  endfunction

  // Accumulate one accepted pixel and, at the row end, queue the wheel command.
  task automatic account_pixel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic last);
    wheel_cmd_t cmd;
    int avg;
    int ofs;
    int base;
    if (col_idx < MAX_WIDTH) begin
      if (r > thr_cfg && g > thr_cfg && b > thr_cfg) begin
        col_sum += col_idx;
        white_cnt++;
      end
      col_idx++;
    end
    if (last) begin
      cmd.steer = STEER_FWD;
      cmd.lost = 1'b0;
      if (white_cnt == 0) begin
        // No white pixel: keep the previous speeds.
        cmd.lost = 1'b1;
      end else begin
        avg = int'(col_sum / white_cnt);
        ofs = int'(width_cfg >> 1) - avg;
        base = int'(base_cfg);
        if (ofs > 0) begin
          held_left = clamp_speed(base);
          held_right = clamp_speed(base + ofs);
          cmd.steer = STEER_LEFT;
        end else if (ofs < 0) begin
          held_left = clamp_speed(base - ofs);
          held_right = clamp_speed(base);
          cmd.steer = STEER_RIGHT;
        end else begin
          held_left = clamp_speed(base);
          held_right = clamp_speed(base);
        end
      end
      cmd.left = held_left;
      cmd.right = held_right;
      cmd_q.push_back(cmd);
      col_idx = '0;
      col_sum = '0;
      white_cnt = '0;
    end
  endtask

  // Queue one pixel; the gap before it is zero inside a burst row.
  task automatic add_pixel(input int r, input int g, input int b, input bit last);
    pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    p.row_end = last;
    p.gap = burst_row ? 0 : $urandom_range(0, 6);
    pixel_q.push_back(p);
  endtask

  // Queue a row of len pixels; from column white_from on, pct percent are white.
  task automatic queue_row(input int len, input int pct, input int white_from);
    int t;
    burst_row = ($urandom_range(0, 3) == 0);
    t = int'(thr_cfg);
    for (int c = 0; c < len; c++) begin
      if (c < white_from) begin
        // Blue at zero never exceeds the threshold.
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255), 0, c == len - 1);
      end else if (t < 255 && $urandom_range(0, 99) < pct) begin
        add_pixel($urandom_range(t + 1, 255), $urandom_range(t + 1, 255),
                  $urandom_range(t + 1, 255), c == len - 1);
      end else begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), c == len - 1);
      end
    end
  endtask

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_THRESH: thr_cfg = val[THR_W-1:0];
      REG_WIDTH:  width_cfg = val[RW_W-1:0];
      REG_BASE:   base_cfg = val[BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int thr, input int width, input int base);
    cfg_write(REG_THRESH, thr);
    cfg_write(REG_WIDTH, width);
    cfg_write(REG_BASE, base);
  endtask

  // Wait until every pixel is taken and every command has come back.
  task automatic drain_results();
    do @(negedge clk); while (pixel_q.size() != 0 || in_tvalid || cmd_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    int n;
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: lost line, white detection edges, held speeds.
    add_pixel(0, 0, 0, 1'b1);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(251, 251, 251, 1'b0);
    add_pixel(250, 255, 255, 1'b0);
    add_pixel(255, 250, 255, 1'b0);
    add_pixel(255, 255, 250, 1'b1);
    add_pixel(255, 255, 255, 1'b1);
    add_pixel(0, 255, 255, 1'b1);
    drain_results();

    // Zero threshold, zero centre, top base speed: right turn, forward, lost.
    set_config(0, 0, 255);
    add_pixel(1, 1, 1, 1'b0);
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(1, 1, 1, 1'b1);
    add_pixel(1, 1, 1, 1'b1);
    add_pixel(0, 0, 0, 1'b1);
    drain_results();

    // Top threshold leaves nothing white; widest register value.
    set_config(255, 2047, 0);
    add_pixel(255, 255, 255, 1'b1);
    drain_results();

    // Unit width with zero base: centre column zero, straight ahead.
    set_config(254, 1, 0);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(255, 255, 255, 1'b1);
    drain_results();

    // Random rows under a few random settings.
    for (int ph = 0; ph < 4; ph++) begin
      set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(100, 250),
                 $urandom_range(1, 120), $urandom_range(0, 255));
      n = 0;
      while (n < 100) begin
        len = $urandom_range(1, int'(width_cfg) + 10);
        queue_row(len, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 100), 0);
        n += len;
      end
      drain_results();
    end

    // A row past the longest counted row: white columns beyond it must not count.
    set_config(128, 0, 255);
    queue_row(MAX_WIDTH + 20, 100, MAX_WIDTH - 24);
    drain_results();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Pixel driver: presents queued pixels after their idle gaps.
  int     gap_cnt = 0;
  pixel_t cur_pix;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt = 0;
    end else if (!in_tvalid || in_tready) begin
      if (pixel_q.size() != 0 && gap_cnt >= pixel_q[0].gap) begin
        cur_pix = pixel_q.pop_front();
        in_tdata <= {cur_pix.blue, cur_pix.green, cur_pix.red};
        in_tlast <= cur_pix.row_end;
        in_tvalid <= 1'b1;
        gap_cnt = 0;
      end else begin
        in_tvalid <= 1'b0;
        if (pixel_q.size() != 0) begin
          gap_cnt++;
        end
      end
    end
  end

  // Result receiver: random stalls per word, and long hold-offs at two points.
  int stall_left = 0;
  int hold_left = 0;
  int pix_seen = 0;
  bit fast_rx = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pix_seen++;
        if (pix_seen == 120 || pix_seen == 700) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 7) == 0) begin
          fast_rx = !fast_rx;
        end
        stall_left = fast_rx ? 0 : $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted pixel, check every accepted command word.
  wheel_cmd_t exp_cmd;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        account_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (cmd_q.size() == 0) begin
          $error("unexpected command word: data %h, line_lost %b", out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          exp_cmd = cmd_q.pop_front();
          if (out_tdata[10:0] !== exp_cmd.left) begin
            $error("left_speed_half: expected %0d, actual %0d",
                   exp_cmd.left, out_tdata[10:0]);
            mismatch_count++;
          end
          if (out_tdata[21:11] !== exp_cmd.right) begin
            $error("right_speed_half: expected %0d, actual %0d",
                   exp_cmd.right, out_tdata[21:11]);
            mismatch_count++;
          end
          if (out_tdata[23:22] !== exp_cmd.steer) begin
            $error("steer: expected %0d, actual %0d", exp_cmd.steer, out_tdata[23:22]);
            mismatch_count++;
          end
          if (out_tuser !== exp_cmd.lost) begin
            $error("line_lost: expected %0d, actual %0d", exp_cmd.lost, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any word or register write moving.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
